### src/assert_macros.svh
// Assertion macros used by the checker file of the page victim selector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define PVS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define PVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pvs_pkg.sv
// Package of the page victim selector: sizes, codes, word types, popcount.
// No dependencies.
package pvs_pkg;

    localparam int SLOTS     = 16;
    localparam int AGE_BITS  = 32;
    localparam int PAGE_BITS = 20;

    // Fixed field widths of the channel words
    localparam int PAGE_FIELD_W = 20;
    localparam int SLOT_FIELD_W = 4;
    localparam int AGE_FIELD_W  = 32;
    localparam int RES_W        = 5;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int POP_W     = $clog2(AGE_BITS + 1);
    localparam int IDX_CMP_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam int NIB_N     = (AGE_BITS + 3) / 4;
    localparam int NIB_W     = NIB_N * 4;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Byte address of the policy register
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_POLICY = '0;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_REMOVE    = 2'd1,
        KIND_WRITE_AGE = 2'd2,
        KIND_VICTIM    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                    kind;
        logic [PAGE_FIELD_W-1:0]  page_number;
        logic [SLOT_FIELD_W-1:0]  slot_index;
        logic [AGE_FIELD_W-1:0]   age_value;
    } in_word_t;

    typedef struct packed {
        status_t                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [RES_W-1:0]         resident_pages;
    } out_word_t;

    // Request word handed from cell to cell along the row
    typedef struct packed {
        kind_t                    kind;
        logic                     policy;
        logic [PAGE_BITS-1:0]     page;
        logic [SLOT_FIELD_W-1:0]  sidx;
        logic [AGE_BITS-1:0]      age;
        logic                     found;
        logic [AGE_BITS-1:0]      best_age;
        logic [POP_W-1:0]         best_pop;
        logic [SLOT_FIELD_W-1:0]  slot;
    } tok_t;

    // Set bits of an age: per-nibble counts, then a short sum
    function automatic logic [POP_W-1:0] age_pop(input logic [AGE_BITS-1:0] a);
        logic [NIB_W-1:0] padded;
        logic [POP_W-1:0] sum;
        logic [2:0]       nib_cnt;
        padded = NIB_W'(a);
        sum    = '0;
        for (int n = 0; n < NIB_N; n++) begin
            nib_cnt = 3'(padded[4*n]) + 3'(padded[4*n+1])
                    + 3'(padded[4*n+2]) + 3'(padded[4*n+3]);
            sum = sum + POP_W'(nib_cnt);
        end
        return sum;
    endfunction

endpackage

### src/page_victim_selector_unit.sv
// Page victim selector: a row of SLOTS slot cells (16 here) with insert, remove,
// age write and victim selection under the NFUA or LAPA policy register.
// Depends on pvs_pkg and pvs_cell.
//
// Each accepted word travels down the row of cells, one cell per cycle, and every
// cell acts on it as it passes; after the last cell the result is registered into
// the output register. One word is in the row at a time: the next word is taken
// only once the current one has left the last cell. A finished result may wait on
// the output while the next word is taken; a second finished result then waits in
// a holding register and the input stays closed until it moves on. Valid marks
// clear at reset, so no clearing pass is needed. The policy register (address 0)
// is written over APB and is latched into each word at acceptance.
module page_victim_selector_unit import pvs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             policy_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_vld_reg, pend_vld_reg;
    out_word_t        m_data_reg, pend_reg, res_next;

    logic   s_fire, m_free, end_vld, cfg_wr, cfg_sel;
    tok_t   head_tok, end_tok;
    logic   chain_vld [SLOTS];
    tok_t   chain_tok [SLOTS];

    assign s_ready = !busy_reg && !pend_vld_reg;
    assign s_fire  = s_valid && s_ready;
    assign pready  = 1'b1;
    assign cfg_sel = (paddr == CFG_ADDR_POLICY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? CFG_DATA_W'(policy_reg) : '0;

    always_comb begin
        head_tok          = '0;
        head_tok.kind     = s_data.kind;
        head_tok.policy   = policy_reg;
        head_tok.page     = PAGE_BITS'(s_data.page_number);
        head_tok.sidx     = s_data.slot_index;
        head_tok.age      = AGE_BITS'(s_data.age_value);
        head_tok.found    = 1'b0;
        head_tok.best_age = '0;
        head_tok.best_pop = '0;
        head_tok.slot     = (s_data.kind == KIND_WRITE_AGE) ? s_data.slot_index : '0;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            pvs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (SLOT_W'(g)),
                .in_vld   (s_fire),
                .in_tok   (head_tok),
                .out_vld  (chain_vld[g]),
                .out_tok  (chain_tok[g])
            );
        end else begin : g_body
            pvs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (SLOT_W'(g)),
                .in_vld   (chain_vld[g-1]),
                .in_tok   (chain_tok[g-1]),
                .out_vld  (chain_vld[g]),
                .out_tok  (chain_tok[g])
            );
        end
    end

    assign end_vld = chain_vld[SLOTS-1];
    assign end_tok = chain_tok[SLOTS-1];
    assign m_free  = !m_vld_reg || m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        res_next = '0;
        res_next.slot = end_tok.slot;
        case (end_tok.kind)
            KIND_INSERT: begin
                if (end_tok.found) begin
                    cnt_next        = cnt_reg + CNT_W'(1);
                    res_next.status = ST_OK;
                end else begin
                    res_next.status = ST_FULL;
                end
            end
            KIND_REMOVE: begin
                if (end_tok.found) begin
                    cnt_next        = cnt_reg - CNT_W'(1);
                    res_next.status = ST_OK;
                end else begin
                    res_next.status = ST_NOT_FOUND;
                end
            end
            KIND_WRITE_AGE: res_next.status = ST_OK;
            KIND_VICTIM:    res_next.status = end_tok.found ? ST_OK : ST_EMPTY;
            default:        res_next.status = ST_OK;
        endcase
        res_next.resident_pages = RES_W'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= 1'b0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_vld_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                policy_reg <= pwdata[0];
            end
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (end_vld) begin
                busy_reg <= 1'b0;
            end
            if (end_vld) begin
                cnt_reg <= cnt_next;
            end
            if (m_free) begin
                m_vld_reg    <= pend_vld_reg || end_vld;
                pend_vld_reg <= 1'b0;
            end else if (end_vld) begin
                pend_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_free) begin
            if (pend_vld_reg) begin
                m_data_reg <= pend_reg;
            end else if (end_vld) begin
                m_data_reg <= res_next;
            end
        end else if (end_vld) begin
            pend_reg <= res_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

### src/pvs_cell.sv
// One slot of the page victim selector: page, valid mark, age and its popcount.
// Acts on the request word passing through and registers it for the next cell.
// Depends on pvs_pkg.
module pvs_cell import pvs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic              in_vld,
    input  tok_t              in_tok,
    output logic              out_vld,
    output tok_t              out_tok
);

    logic                 valid_reg, valid_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [AGE_BITS-1:0]  age_reg, age_next;
    logic [POP_W-1:0]     pop_reg, pop_next;
    logic                 out_vld_reg;
    tok_t                 out_tok_reg, tok_next;

    logic [AGE_BITS-1:0]     fresh_age;
    logic [POP_W-1:0]        fresh_pop;
    logic                    idx_hit;
    logic [SLOT_FIELD_W-1:0] my_slot;
    logic                    age_le, pop_lt, pop_eq, take;

    always_comb begin
        fresh_age = in_tok.policy ? '1 : '0;
        fresh_pop = in_tok.policy ? POP_W'(AGE_BITS) : '0;
        idx_hit   = (IDX_CMP_W'(in_tok.sidx) == IDX_CMP_W'(cell_idx));
        my_slot   = SLOT_FIELD_W'(cell_idx);
        age_le    = (age_reg <= in_tok.best_age);
        pop_lt    = (pop_reg < in_tok.best_pop);
        pop_eq    = (pop_reg == in_tok.best_pop);
        // later slots win ties, hence <=
        if (!in_tok.found) begin
            take = 1'b1;
        end else if (!in_tok.policy) begin
            take = age_le;
        end else begin
            take = pop_lt || (pop_eq && age_le);
        end

        valid_next = valid_reg;
        page_next  = page_reg;
        age_next   = age_reg;
        pop_next   = pop_reg;
        tok_next   = in_tok;

        if (in_vld) begin
            case (in_tok.kind)
                KIND_INSERT: begin
                    if (!in_tok.found && !valid_reg) begin
                        valid_next     = 1'b1;
                        page_next      = in_tok.page;
                        age_next       = fresh_age;
                        pop_next       = fresh_pop;
                        tok_next.found = 1'b1;
                        tok_next.slot  = my_slot;
                    end
                end
                KIND_REMOVE: begin
                    if (!in_tok.found && valid_reg && page_reg == in_tok.page) begin
                        valid_next     = 1'b0;
                        age_next       = fresh_age;
                        pop_next       = fresh_pop;
                        tok_next.found = 1'b1;
                        tok_next.slot  = my_slot;
                    end
                end
                KIND_WRITE_AGE: begin
                    if (idx_hit) begin
                        age_next = in_tok.age;
                        pop_next = age_pop(in_tok.age);
                    end
                end
                KIND_VICTIM: begin
                    if (valid_reg && take) begin
                        tok_next.found    = 1'b1;
                        tok_next.best_age = age_reg;
                        tok_next.best_pop = pop_reg;
                        tok_next.slot     = my_slot;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            out_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg    <= page_next;
        age_reg     <= age_next;
        pop_reg     <= pop_next;
        out_tok_reg <= tok_next;
    end

    assign out_vld = out_vld_reg;
    assign out_tok = out_tok_reg;

endmodule

### src/pvs_checker.sv
// Port-level checks for page_victim_selector_unit, bound to the top level.
// Depends on pvs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pvs_checker import pvs_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_word_t             m_data,
    input logic                  psel,
    input logic                  pready
);

    // only one word walks the cell row at a time
    `PVS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "word accepted while another is in flight")

    `PVS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result word changed")

    // a full table reports every slot resident
    `PVS_ASSERT_IMPL(a_full_count, aclk, aresetn, m_valid && m_data.status == ST_FULL, m_data.resident_pages == RES_W'(SLOTS), "full status with free slots")

    `PVS_ASSERT_IMPL(a_empty_count, aclk, aresetn, m_valid && m_data.status == ST_EMPTY, m_data.resident_pages == '0, "empty status with resident pages")

    `PVS_ASSERT(a_pready_high, aclk, aresetn, pready || !psel, "config port not ready")

endmodule

bind page_victim_selector_unit pvs_checker u_pvs_checker (.*);

### sim/page_victim_selector_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of page_victim_selector_unit: a mirror of the slot table predicts every
// result word; random stalls on both channels, policy changes over APB between phases.
// Depends on pvs_pkg and the unit RTL.

module page_victim_selector_unit_tb;
    import pvs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int WORD_LATENCY  = SLOTS + 1;
    localparam int SETTLE_CYCLES = 2 * WORD_LATENCY + 4;
    localparam int QUIET_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 280;
    localparam int REG_POLICY    = 0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_POLICY = CFG_ADDR_W'(4 * REG_POLICY);
    localparam logic POLICY_NFUA = 1'b0;
    localparam logic POLICY_LAPA = 1'b1;
    localparam logic [AGE_BITS-1:0] AGE_ONES = '1;

    // Mirror of the slot table and the queue of result words it predicts
    class page_table_mirror;
        logic [PAGE_BITS-1:0] page_of [SLOTS];
        bit                   held [SLOTS];
        logic [AGE_BITS-1:0]  age_of [SLOTS];
        int                   resident;
        bit                   lapa;
        out_word_t            pending_results[$];
        int                   mismatches;

        function logic [AGE_BITS-1:0] fresh_age();
            return lapa ? AGE_ONES : '0;
        endfunction

        function out_word_t predict(in_word_t w);
            out_word_t           r;
            bit                  done;
            bit                  take;
            int                  pop;
            int                  best_pop;
            logic [AGE_BITS-1:0] best_age;
            r.status = ST_OK;
            r.slot = '0;
            done = 1'b0;
            best_pop = 0;
            best_age = '0;
            case (w.kind)
                KIND_INSERT: begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!done && !held[i]) begin
                            held[i] = 1'b1;
                            page_of[i] = w.page_number[PAGE_BITS-1:0];
                            age_of[i] = fresh_age();
                            resident++;
                            r.status = ST_OK;
                            r.slot = SLOT_FIELD_W'(i);
                            done = 1'b1;
                        end
                    end
                end
                KIND_REMOVE: begin
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!done && held[i] && page_of[i] == w.page_number[PAGE_BITS-1:0]) begin
                            held[i] = 1'b0;
                            age_of[i] = fresh_age();
                            if (resident > 0)
                                resident--;
                            r.status = ST_OK;
                            r.slot = SLOT_FIELD_W'(i);
                            done = 1'b1;
                        end
                    end
                end
                KIND_WRITE_AGE: begin
                    if (int'(w.slot_index) < SLOTS)
                        age_of[w.slot_index] = w.age_value[AGE_BITS-1:0];
                    r.slot = w.slot_index;
                end
                default: begin
                    // later slots win ties, hence <=
                    for (int i = 0; i < SLOTS; i++) begin
                        if (held[i]) begin
                            pop = $countones(age_of[i]);
                            if (!done)
                                take = 1'b1;
                            else if (!lapa)
                                take = age_of[i] <= best_age;
                            else
                                take = pop < best_pop || (pop == best_pop && age_of[i] <= best_age);
                            if (take) begin
                                done = 1'b1;
                                best_age = age_of[i];
                                best_pop = pop;
                                r.slot = SLOT_FIELD_W'(i);
                            end
                        end
                    end
                    if (!done) begin
                        r.status = ST_EMPTY;
                        r.slot = '0;
                    end
                end
            endcase
            r.resident_pages = RES_W'(resident);
            return r;
        endfunction

        function void note_word(in_word_t w);
            pending_results.push_back(predict(w));
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: status %0d slot %0d resident %0d",
                             got.status, got.slot, got.resident_pages);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.slot !== want.slot
                || got.resident_pages !== want.resident_pages) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected status %0d slot %0d resident %0d, got %0d %0d %0d",
                             want.status, want.slot, want.resident_pages,
                             got.status, got.slot, got.resident_pages);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    page_table_mirror      mirror = new();
    int                    gap_pct = 20;
    int                    stall_pct = 20;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;
    logic [PAGE_BITS-1:0]  page_pool [8];
    logic [AGE_BITS-1:0]   tie_age;

    page_victim_selector_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // receiver: drops m_ready in random stall bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                mirror.check_word(m_data);
            if (s_valid && s_ready)
                mirror.note_word(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: %0d cycles without a transfer", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input in_word_t w);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_item(input kind_t k, input logic [PAGE_FIELD_W-1:0] pg,
                             input logic [SLOT_FIELD_W-1:0] si,
                             input logic [AGE_FIELD_W-1:0] av);
        in_word_t w;
        w.kind = k;
        w.page_number = pg;
        w.slot_index = si;
        w.age_value = av;
        send_word(w);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write the policy, then read it back
    task automatic write_policy(input logic p);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_POLICY;
        pwdata <= (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(p);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        mirror.lapa = p;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== CFG_DATA_W'(p)) begin
            mirror.mismatches++;
            if (mirror.mismatches <= REPORT_MAX)
                $display("policy readback: expected %0d, got %0h", p, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [AGE_BITS-1:0] pick_age();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return AGE_ONES;
            2: return AGE_BITS'($urandom());
            3: return AGE_BITS'($urandom_range(0, 7));
            4: return AGE_BITS'(1) << $urandom_range(0, AGE_BITS - 1);
            5: return tie_age;
            6: return ~(AGE_BITS'(1) << $urandom_range(0, AGE_BITS - 1));
            default: return AGE_BITS'($urandom() & $urandom() & $urandom());
        endcase
    endfunction

    // filling leans on inserts so the table runs full; draining empties it
    function automatic in_word_t pick_word(input bit filling);
        in_word_t w;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 45 : 12))
            w.kind = KIND_INSERT;
        else if (roll < 55)
            w.kind = KIND_REMOVE;
        else if (roll < 75)
            w.kind = KIND_WRITE_AGE;
        else
            w.kind = KIND_VICTIM;
        if ($urandom_range(0, 4) == 0)
            w.page_number = PAGE_FIELD_W'($urandom());
        else
            w.page_number = page_pool[$urandom_range(0, 7)];
        w.slot_index = SLOT_FIELD_W'($urandom());
        w.age_value = pick_age();
        return w;
    endfunction

    initial begin : stimulus
        bit   filling;
        bit   last_phase;
        logic phase_policy;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_policy(POLICY_NFUA);

        // least age: empty table, misses, ties, free-slot write, duplicates
        send_item(KIND_VICTIM,    20'hFFFFF, 4'hF, '1);
        send_item(KIND_REMOVE,    20'h12345, 4'h0, '0);
        send_item(KIND_INSERT,    20'h00000, 4'h0, '0);
        send_item(KIND_INSERT,    20'hFFFFF, 4'hF, '1);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h0, '1);
        send_item(KIND_WRITE_AGE, 20'hFFFFF, 4'h1, '0);
        send_item(KIND_VICTIM,    20'h00000, 4'h0, '0);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h1, '1);
        send_item(KIND_VICTIM,    20'hFFFFF, 4'hF, '1);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'hF, 32'h5555_5555);
        send_item(KIND_REMOVE,    20'h00000, 4'h0, '0);
        send_item(KIND_REMOVE,    20'h00000, 4'h0, '0);
        send_item(KIND_INSERT,    20'hFFFFF, 4'h0, '0);
        send_item(KIND_REMOVE,    20'hFFFFF, 4'h0, '0);
        drain_results();
        write_policy(POLICY_LAPA);

        // fewest set bits: bit count beats value, then value, then last slot
        send_item(KIND_INSERT,    20'hABCDE, 4'h0, '0);
        send_item(KIND_VICTIM,    20'h00000, 4'h0, '0);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h0, 32'h8000_0000);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h1, 32'h0000_0003);
        send_item(KIND_VICTIM,    20'h00000, 4'h0, '0);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h1, 32'h0000_0001);
        send_item(KIND_VICTIM,    20'h00000, 4'h0, '0);
        send_item(KIND_WRITE_AGE, 20'h00000, 4'h0, 32'h0000_0001);
        send_item(KIND_VICTIM,    20'h00000, 4'h0, '0);
        send_item(KIND_REMOVE,    20'hABCDE, 4'h0, '0);
        send_item(KIND_REMOVE,    20'hFFFFF, 4'h0, '0);

        for (int p = 0; p < PHASES; p++) begin
            last_phase = (p == PHASES - 1);
            phase_policy = (p % 3 != 1) ? POLICY_LAPA : POLICY_NFUA;
            drain_results();
            write_policy(phase_policy);
            foreach (page_pool[i])
                page_pool[i] = PAGE_BITS'($urandom());
            page_pool[7] = p[0] ? '0 : '1;
            tie_age = AGE_BITS'($urandom() & $urandom());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 60 == 0) begin
                    if (last_phase || $urandom_range(0, 3) == 0) begin
                        gap_pct = 0;
                        stall_pct = 0;
                    end else begin
                        gap_pct = $urandom_range(5, 40);
                        stall_pct = $urandom_range(5, 40);
                    end
                end
                filling = ((n / 48) % 2) == 0;
                if (!last_phase && $urandom_range(0, 199) == 0)
                    drain_results();
                send_word(pick_word(filling));
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
